@@ src/shabs_pkg.sv @@
// shared types and constants for the byte stream hasher
`default_nettype none

package shabs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_FINAL
  } state_t;

  // eight 32-bit words, element 0 is word 0 (H0 or a)
  typedef logic [7:0][31:0] chain_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       load_vars;
    logic       round;
    logic [5:0] round_idx;
    logic       update;
    logic       init_chain;
  } core_ctl_t;

  localparam chain_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

@@ src/shabs_if.sv @@
// valid/ready channel interfaces for message bytes and digest words
`default_nettype none

interface shabs_msg_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface shabs_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

`default_nettype wire

@@ src/shabs_core.sv @@
// single-round sha-256 compression unit with byte-fed message schedule
`default_nettype none

module shabs_core (
  input  logic                  clk,
  input  logic                  rst,
  input  shabs_pkg::core_ctl_t  ctl,
  output shabs_pkg::chain_t     chain
);
  import shabs_pkg::*;

  // win[511:480] is the current schedule word w[t], win[31:0] is w[t+15]
  logic [511:0] win;
  chain_t       vars;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  ch;
  logic [31:0]  mj;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  always_comb begin
    // w[t+16] from w[t+14], w[t+9], w[t+1], w[t]
    w_new = ssig1(win[63:32]) + win[223:192] + ssig0(win[479:448]) + win[511:480];
    ch    = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    mj    = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1    = vars[7] + bsig1(vars[4]) + ch + ROUND_K[ctl.round_idx] + win[511:480];
    t2    = bsig0(vars[0]) + mj;
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      win <= {win[503:0], ctl.byte_val};
    end else if (ctl.round) begin
      win <= {win[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_vars) begin
      vars <= chain;
    end else if (ctl.round) begin
      vars <= {vars[6], vars[5], vars[4], vars[3] + t1, vars[2], vars[1], vars[0], t1 + t2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= INIT_H;
    end else if (ctl.init_chain) begin
      chain <= INIT_H;
    end else if (ctl.update) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + vars[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ src/sha256_byte_stream_hasher.sv @@
// sha-256 hasher top level: byte intake, padding sequencer and digest output
//
//  channel  dir  transaction                        payload
//  msg      in   one message byte or a finish       func, data_byte
//  dig      out  one digest word, eight per finish  digest_word, word_index, last
//
// an absorb byte is taken in the idle state; the 64th byte of a block starts compression
// (64 rounds through the single round unit, then one chaining add).
// a finish pads the buffered bytes out to a full block and compresses it, pads and
// compresses one more block when 56 or more bytes are buffered, and then loads the
// digest register.
// digest words drain from their own register, so new transactions are taken meanwhile;
// a finish stalls in its digest load cycle until the previous digest has gone out.
// rst is synchronous and returns the block to the start of an empty message.
`default_nettype none

module sha256_byte_stream_hasher (
  input  logic              clk,
  input  logic              rst,
  shabs_msg_if.sink         msg,
  shabs_dig_if.source       dig
);
  import shabs_pkg::*;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [2:0] LEN_ZONE   = 3'b111;

  state_t      state;
  state_t      state_next;
  core_ctl_t   ctl;
  chain_t      chain;

  logic [5:0]  fill;
  logic [5:0]  round_cnt;
  logic [54:0] msg_blocks;
  logic [63:0] len;
  logic        padding;
  logic        extra_blk;
  logic        pad_first;
  logic        fin_accept;
  logic        len_byte;
  logic        final_load;
  logic        block_done;

  chain_t      dig_words;
  logic        out_busy;
  logic [2:0]  out_idx;
  logic        out_take;

  shabs_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .chain (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl            = '0;
    ctl.round_idx  = round_cnt;
    msg.ready      = 1'b0;
    fin_accept     = 1'b0;
    len_byte       = 1'b0;
    final_load     = 1'b0;
    block_done     = 1'b0;
    case (state)
      ST_IDLE: begin
        msg.ready = 1'b1;
        if (msg.valid) begin
          if (!msg.func) begin
            ctl.shift_byte = 1'b1;
            ctl.byte_val   = msg.data_byte;
            if (fill == FILL_LAST) begin
              ctl.load_vars = 1'b1;
              state_next    = ST_ROUND;
            end
          end else begin
            fin_accept = 1'b1;
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.shift_byte = 1'b1;
        if (pad_first) begin
          ctl.byte_val = 8'h80;
        end else if (extra_blk || fill[5:3] != LEN_ZONE) begin
          ctl.byte_val = 8'h00;
        end else begin
          ctl.byte_val = len[63:56];
          len_byte     = 1'b1;
        end
        if (fill == FILL_LAST) begin
          ctl.load_vars = 1'b1;
          state_next    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.round = 1'b1;
        if (round_cnt == ROUND_LAST) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
        block_done = 1'b1;
        if (!padding) begin
          state_next = ST_IDLE;
        end else if (extra_blk) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!out_busy) begin
          final_load     = 1'b1;
          ctl.init_chain = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      round_cnt <= '0;
    end else begin
      if (ctl.shift_byte) begin
        fill <= fill + 6'd1;
      end
      round_cnt <= ctl.round ? round_cnt + 6'd1 : '0;
    end
  end

  // the bit count of completed blocks is a multiple of 512, so only blocks are counted
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_blocks <= '0;
    end else if (final_load) begin
      msg_blocks <= '0;
    end else if (block_done && !padding) begin
      msg_blocks <= msg_blocks + 55'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      padding   <= 1'b0;
      extra_blk <= 1'b0;
      pad_first <= 1'b0;
    end else begin
      if (fin_accept) begin
        padding   <= 1'b1;
        extra_blk <= (fill[5:3] == LEN_ZONE);
        pad_first <= 1'b1;
      end else begin
        if (final_load) begin
          padding <= 1'b0;
        end
        if (block_done) begin
          extra_blk <= 1'b0;
        end
        if (state == ST_PAD) begin
          pad_first <= 1'b0;
        end
      end
    end
  end

  // total length in bits, sent most significant byte first
  always_ff @(posedge clk) begin
    if (fin_accept) begin
      len <= {msg_blocks, fill, 3'b000};
    end else if (len_byte) begin
      len <= {len[55:0], 8'h00};
    end
  end

  assign out_take        = dig.valid && dig.ready;
  assign dig.valid       = out_busy;
  assign dig.digest_word = dig_words[0];
  assign dig.word_index  = out_idx;
  assign dig.last        = (out_idx == WORD_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else if (final_load) begin
      out_busy <= 1'b1;
      out_idx  <= '0;
    end else if (out_take) begin
      out_idx <= out_idx + 3'd1;
      if (out_idx == WORD_LAST) begin
        out_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (final_load) begin
      dig_words <= chain;
    end else if (out_take) begin
      dig_words <= {32'h0, dig_words[7:1]};
    end
  end

  a_block_full: assert property (@(posedge clk) disable iff (rst)
    msg.valid && msg.ready && !msg.func && fill == FILL_LAST |=> state == ST_ROUND)
    else $error("full block did not start compression");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND && round_cnt == ROUND_LAST |=> state == ST_UPDATE)
    else $error("compression did not end after 64 rounds");

  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINAL && !out_busy |=> dig.valid && dig.word_index == 3'd0)
    else $error("digest output did not start at word 0");

  a_extra_pad: assert property (@(posedge clk) disable iff (rst)
    extra_blk |-> padding)
    else $error("extra pad block flagged outside padding");

endmodule

`default_nettype wire

@@ bench/sha256_byte_stream_hasher_tb.sv @@
// self-checking testbench for the sha-256 byte stream hasher
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;

  typedef enum logic {
    FN_ABSORB = 1'b0,
    FN_FINISH = 1'b1
  } func_code_t;

  typedef struct {
    func_code_t func;
    logic [7:0] data;
    bit         drain_first;
  } msg_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam int ITEM_TARGET = 300;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic clk;
  logic rst;

  shabs_msg_if msg_ch ();
  shabs_dig_if dig_ch ();

  sha256_byte_stream_hasher i_dut (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .dig (dig_ch)
  );

  // hash model state
  logic [31:0]  digest_chain [8];
  logic [7:0]   block_buf [64];
  int           buf_fill;
  logic [63:0]  bits_done;

  msg_item_t    pending [$];
  digest_word_t digest_due [$];
  msg_item_t    next_item;

  logic msg_fired;
  int   fail_count;
  int   idle_cycles;
  int   burst_left;
  int   gap_left;
  int   stall_mode;
  int   stall_phase;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] g0, g1, s0, s1, ch, mj, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = digest_chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        g0 = rotr(w[(t-15)%16], 7) ^ rotr(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
        g1 = rotr(w[(t-2)%16], 17) ^ rotr(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
        w[t%16] = w[t%16] + g0 + w[(t-7)%16] + g1;
      end
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + SHA_K[t] + w[t%16];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) digest_chain[i] = digest_chain[i] + v[i];
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) digest_chain[i] = SHA_H0[i];
    buf_fill = 0;
    bits_done = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    block_buf[buf_fill] = b;
    buf_fill++;
    if (buf_fill == 64) begin
      hash_block();
      bits_done = bits_done + 64'd512;
      buf_fill = 0;
    end
  endfunction

  // pad, append the length, compress and queue the eight digest words
  function automatic void finish_message();
    int          pos;
    logic [63:0] total;
    pos = buf_fill;
    total = bits_done + 64'(pos * 8);
    block_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) block_buf[pos++] = 8'h00;
      hash_block();
      pos = 0;
    end
    while (pos < 56) block_buf[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) block_buf[56+i] = total[8*(7-i) +: 8];
    hash_block();
    for (int i = 0; i < 8; i++)
      digest_due.push_back('{word: digest_chain[i], idx: 3'(i), last: (i == 7)});
    restart_message();
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit drain);
    pending.push_back('{func: FN_ABSORB, data: b, drain_first: drain});
  endtask

  task automatic queue_finish(input logic [7:0] junk, input bit drain);
    pending.push_back('{func: FN_FINISH, data: junk, drain_first: drain});
  endtask

  task automatic queue_message(input int len, input bit drain);
    for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)), drain && i == 0);
    queue_finish(8'($urandom_range(0, 255)), drain && len == 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: one transaction per pending item, in bursts with gaps between them
  always @(negedge clk) begin
    if (!rst && (!msg_ch.valid || msg_fired)) begin
      if (gap_left != 0) begin
        gap_left--;
        msg_ch.valid <= 1'b0;
      end else if (pending.size() == 0 ||
                   (pending[0].drain_first && digest_due.size() != 0)) begin
        msg_ch.valid <= 1'b0;
      end else begin
        next_item = pending.pop_front();
        msg_ch.valid <= 1'b1;
        msg_ch.func <= next_item.func;
        msg_ch.data_byte <= next_item.data;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // digest sink backpressure, with a stall mode chosen again at random
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_phase = $urandom_range(16, 80);
    end else begin
      stall_phase--;
    end
    case (stall_mode)
      0: dig_ch.ready <= 1'b1;
      1: dig_ch.ready <= 1'($urandom_range(0, 1));
      default: dig_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: update the hash model on input transactions, check digest words
  always @(posedge clk) begin
    digest_word_t want;
    msg_fired <= !rst && msg_ch.valid && msg_ch.ready;
    if (!rst) begin
      if (msg_ch.valid && msg_ch.ready) begin
        if (msg_ch.func == FN_FINISH) finish_message();
        else absorb_byte(msg_ch.data_byte);
      end
      if (dig_ch.valid && dig_ch.ready) begin
        if (digest_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected digest word %h idx %0d",
                                  dig_ch.digest_word, dig_ch.word_index));
        end else begin
          want = digest_due.pop_front();
          if (dig_ch.digest_word !== want.word)
            flag_mismatch($sformatf("digest_word idx %0d: got %h want %h",
                                    want.idx, dig_ch.digest_word, want.word));
          if (dig_ch.word_index !== want.idx)
            flag_mismatch($sformatf("word_index: got %0d want %0d",
                                    dig_ch.word_index, want.idx));
          if (dig_ch.last !== want.last)
            flag_mismatch($sformatf("last idx %0d: got %b want %b",
                                    want.idx, dig_ch.last, want.last));
        end
      end
      if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
        $display("sha256_byte_stream_hasher regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int boundary_len [10];
    int len;
    int msg_count;
    boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.func = FN_ABSORB;
    msg_ch.data_byte = 8'h00;
    dig_ch.ready = 1'b0;
    msg_fired = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    stall_phase = 0;
    restart_message();

    // empty message with a stray data byte, then "abc", then byte extremes
    queue_finish(8'hff, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h62, 1'b0);
    queue_byte(8'h63, 1'b0);
    queue_finish(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_finish(8'h5a, 1'b0);
    // back to back finishes: reuse after finish on an empty message
    queue_finish(8'ha5, 1'b0);

    // random messages, some sized around the padding and block boundaries
    msg_count = 0;
    while (pending.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) len = boundary_len[$urandom_range(0, 9)];
      else len = $urandom_range(0, 12);
      queue_message(len, msg_count == 0 || msg_count == 8);
      msg_count++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || msg_ch.valid || digest_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (digest_due.size() != 0)
      flag_mismatch($sformatf("%0d digest words never arrived", digest_due.size()));
    if (fail_count == 0)
      $display("sha256_byte_stream_hasher regression: pass");
    else
      $display("sha256_byte_stream_hasher regression: fail");
    $finish;
  end

endmodule
